### src/pig_pkg.sv
// primitive index generator: shared types, constants and the grid table
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package pig_pkg;

    // batch capacities and polygon limit, widened to hold sums without wrap
    localparam logic [16:0] VERTEX_CAPACITY = 17'd4096;
    localparam logic [16:0] INDEX_CAPACITY  = 17'd8192;
    localparam logic [6:0]  POLY_LIMIT      = 7'd64;

    // grid of 3x3 vertices as 8 triangles
    localparam int unsigned GRID_TRIS   = 8;
    localparam logic [3:0]  GRID_VERTS  = 4'd9;
    localparam logic [4:0]  GRID_INDEXS = 5'd24;

    // input command codes; code 7 is unused
    typedef enum logic [2:0] {
        MODE_FAN         = 3'd0,
        MODE_STRIP       = 3'd1,
        MODE_LINE        = 3'd2,
        MODE_GRID        = 3'd3,
        MODE_INDEXED_FAN = 3'd4,
        MODE_FLUSH_TRI   = 3'd5,
        MODE_FLUSH_LINE  = 3'd6
    } t_mode;

    // result kinds
    typedef enum logic [1:0] {
        KIND_TRIANGLE = 2'd0,
        KIND_LINE     = 2'd1,
        KIND_REPORT   = 2'd2,
        KIND_ERROR    = 2'd3
    } t_kind;

    // how the emit sequence builds each word
    typedef enum logic [1:0] {
        OP_SINGLE = 2'd0,
        OP_FAN    = 2'd1,
        OP_STRIP  = 2'd2,
        OP_GRID   = 2'd3
    } t_op;

    // indexed fan progress
    typedef enum logic [1:0] {
        FAN_CLOSED = 2'd0,
        FAN_BASE   = 2'd1,
        FAN_OPEN   = 2'd2
    } t_fan;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EVAL = 2'd1,
        S_EMIT = 2'd2
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic has_result;
        logic last;
    } t_sts;

    localparam logic [3:0] GRID_TAB [24] = '{
        4'd0, 4'd1, 4'd3,  4'd1, 4'd4, 4'd3,  4'd1, 4'd2, 4'd4,  4'd2, 4'd5, 4'd4,
        4'd3, 4'd4, 4'd6,  4'd4, 4'd7, 4'd6,  4'd4, 4'd5, 4'd7,  4'd5, 4'd8, 4'd7
    };

    // local vertex of corner j of grid triangle k
    function automatic logic [3:0] grid_idx(input logic [2:0] k, input logic [1:0] j);
        logic [4:0] idx;
        idx = 5'({k, 1'b0}) + 5'(k) + 5'(j);
        return GRID_TAB[idx];
    endfunction

endpackage

`default_nettype wire

### src/pig_in_if.sv
// input channel of the primitive index generator: valid, ready and one command word
// no dependencies
`default_nettype none

interface pig_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [6:0]  vertex_count;
    logic [15:0] index_offset;
    logic [7:0]  local_index;
    logic        first_of_list;

    modport source (
        output valid, mode, vertex_count, index_offset, local_index, first_of_list,
        input  ready
    );
    modport sink (
        input  valid, mode, vertex_count, index_offset, local_index, first_of_list,
        output ready
    );
endinterface

`default_nettype wire

### src/pig_out_if.sv
// result channel of the primitive index generator: valid, ready and one result word
// no dependencies
`default_nettype none

interface pig_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] index_a;
    logic [15:0] index_b;
    logic [15:0] index_c;
    logic [15:0] write_position;
    logic [15:0] vertex_total;
    logic        last;

    modport source (
        output valid, kind, index_a, index_b, index_c, write_position,
               vertex_total, last,
        input  ready
    );
    modport sink (
        input  valid, kind, index_a, index_b, index_c, write_position,
               vertex_total, last,
        output ready
    );
endinterface

`default_nettype wire

### src/pig_ctrl.sv
// controller of the primitive index generator: accept, evaluate, emit sequence
// and the result valid flag; depends on pig_pkg
`default_nettype none

module pig_ctrl import pig_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.has_result ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // a word is never loaded over one that is still waiting
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten while stalled");

    // an accepted command is evaluated in the next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EVAL))
        else $error("accepted command not evaluated");

    // the last word of a command ends the emit sequence
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.last) |=> (r_state == S_IDLE && r_out_valid))
        else $error("emit sequence did not close on last word");
`endif

endmodule

`default_nettype wire

### src/pig_dpath.sv
// datapath of the primitive index generator: batch counters, indexed fan state,
// capacity checks and the result word register; depends on pig_pkg
`default_nettype none

module pig_dpath import pig_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [2:0]  i_mode,
    input  wire logic [6:0]  i_vertex_count,
    input  wire logic [15:0] i_index_offset,
    input  wire logic [7:0]  i_local_index,
    input  wire logic        i_first_of_list,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_index_a,
    output logic [15:0]      o_index_b,
    output logic [15:0]      o_index_c,
    output logic [15:0]      o_write_position,
    output logic [15:0]      o_vertex_total,
    output logic             o_last
);

    // captured command word
    t_mode       r_mode;
    logic [6:0]  r_n;
    logic [15:0] r_off;
    logic [7:0]  r_loc;
    logic        r_first;

    // batch and indexed fan state
    logic [15:0] r_tri_v, n_tri_v;
    logic [15:0] r_tri_ix, n_tri_ix;
    logic [15:0] r_line_v, n_line_v;
    logic [15:0] r_line_ix, n_line_ix;
    logic [15:0] r_fan_base, n_fan_base;
    logic [15:0] r_fan_prev, n_fan_prev;
    t_fan        r_fan_seen, n_fan_seen;

    // emit sequence
    t_op         r_op;
    logic [5:0]  r_count;
    logic [5:0]  r_k;
    logic [15:0] r_v;
    logic [15:0] r_vk;
    logic [15:0] r_wp;
    t_kind       r_s_kind;
    logic [15:0] r_s_a, r_s_b, r_s_c, r_s_wp, r_s_vt;

    // result word
    logic [1:0]  r_kind;
    logic [15:0] r_a, r_b, r_c, r_out_wp, r_out_vt;
    logic        r_last;

    // next result word
    logic [1:0]  w_kind;
    logic [15:0] w_a, w_b, w_c, w_wp, w_vt;

    // evaluation results
    t_op         e_op;
    logic [5:0]  e_count;
    t_kind       e_kind;
    logic [15:0] e_a, e_b, e_c, e_wp, e_vt;
    logic [6:0]  tris;
    logic [8:0]  idx_add;
    logic        poly_fit, grid_fit, line_fit, ifan_fit;
    logic [15:0] cur;

    // capture the accepted command
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= t_mode'(i_mode);
            r_n     <= i_vertex_count;
            r_off   <= i_index_offset;
            r_loc   <= i_local_index;
            r_first <= i_first_of_list;
        end
    end

    // capacity checks against the counts before the command
    always_comb begin
        tris     = (r_n >= 7'd3) ? (r_n - 7'd2) : 7'd0;
        idx_add  = {1'b0, tris, 1'b0} + {2'b00, tris};
        poly_fit = (({1'b0, r_tri_v} + 17'(r_n)) <= VERTEX_CAPACITY) &&
                   (({1'b0, r_tri_ix} + 17'(idx_add)) <= INDEX_CAPACITY);
        grid_fit = (({1'b0, r_tri_v} + 17'(GRID_VERTS)) <= VERTEX_CAPACITY) &&
                   (({1'b0, r_tri_ix} + 17'(GRID_INDEXS)) <= INDEX_CAPACITY);
        line_fit = (({1'b0, r_line_v} + 17'd2) <= VERTEX_CAPACITY) &&
                   (({1'b0, r_line_ix} + 17'd2) <= INDEX_CAPACITY);
        ifan_fit = (({1'b0, r_tri_ix} + 17'd3) <= INDEX_CAPACITY);
        cur      = r_off + 16'(r_loc);
    end

    // decide what the command does; errors change no state
    always_comb begin
        e_op       = OP_SINGLE;
        e_count    = 6'd0;
        e_kind     = KIND_ERROR;
        e_a        = '0;
        e_b        = '0;
        e_c        = '0;
        e_wp       = '0;
        e_vt       = '0;
        n_tri_v    = r_tri_v;
        n_tri_ix   = r_tri_ix;
        n_line_v   = r_line_v;
        n_line_ix  = r_line_ix;
        n_fan_base = r_fan_base;
        n_fan_prev = r_fan_prev;
        n_fan_seen = r_fan_seen;
        case (r_mode)
            MODE_FAN, MODE_STRIP: begin
                if (r_n > POLY_LIMIT || !poly_fit) begin
                    e_count = 6'd1;
                end else begin
                    e_op     = (r_mode == MODE_FAN) ? OP_FAN : OP_STRIP;
                    e_count  = tris[5:0];
                    n_tri_v  = r_tri_v + 16'(r_n);
                    n_tri_ix = r_tri_ix + 16'(idx_add);
                end
            end
            MODE_LINE: begin
                e_count = 6'd1;
                if (line_fit) begin
                    e_kind    = KIND_LINE;
                    e_a       = r_line_v;
                    e_b       = r_line_v + 16'd1;
                    e_wp      = r_line_ix;
                    n_line_v  = r_line_v + 16'd2;
                    n_line_ix = r_line_ix + 16'd2;
                end
            end
            MODE_GRID: begin
                e_count = 6'd1;
                if (grid_fit) begin
                    e_op     = OP_GRID;
                    e_count  = 6'(GRID_TRIS);
                    n_tri_v  = r_tri_v + 16'(GRID_VERTS);
                    n_tri_ix = r_tri_ix + 16'(GRID_INDEXS);
                end
            end
            MODE_INDEXED_FAN: begin
                if (r_first) begin
                    n_fan_base = cur;
                    n_fan_seen = FAN_BASE;
                end else if (r_fan_seen == FAN_BASE) begin
                    n_fan_prev = cur;
                    n_fan_seen = FAN_OPEN;
                end else if (r_fan_seen != FAN_CLOSED) begin
                    e_count = 6'd1;
                    if (ifan_fit) begin
                        e_kind     = KIND_TRIANGLE;
                        e_a        = r_fan_base;
                        e_b        = r_fan_prev;
                        e_c        = cur;
                        e_wp       = r_tri_ix;
                        n_fan_prev = cur;
                        n_tri_ix   = r_tri_ix + 16'd3;
                    end
                end
            end
            MODE_FLUSH_TRI: begin
                e_count  = 6'd1;
                e_kind   = KIND_REPORT;
                e_wp     = r_tri_ix;
                e_vt     = r_tri_v;
                n_tri_v  = '0;
                n_tri_ix = '0;
            end
            MODE_FLUSH_LINE: begin
                e_count   = 6'd1;
                e_kind    = KIND_REPORT;
                e_wp      = r_line_ix;
                e_vt      = r_line_v;
                n_line_v  = '0;
                n_line_ix = '0;
            end
            default: begin
                e_count = 6'd0;
            end
        endcase
    end

    // batch and indexed fan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri_v    <= '0;
            r_tri_ix   <= '0;
            r_line_v   <= '0;
            r_line_ix  <= '0;
            r_fan_base <= '0;
            r_fan_prev <= '0;
            r_fan_seen <= FAN_CLOSED;
        end else if (i_cmd.eval) begin
            r_tri_v    <= n_tri_v;
            r_tri_ix   <= n_tri_ix;
            r_line_v   <= n_line_v;
            r_line_ix  <= n_line_ix;
            r_fan_base <= n_fan_base;
            r_fan_prev <= n_fan_prev;
            r_fan_seen <= n_fan_seen;
        end
    end

    // emit sequence setup and stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_op     <= e_op;
            r_count  <= e_count;
            r_k      <= '0;
            r_v      <= r_tri_v;
            r_vk     <= r_tri_v;
            r_wp     <= r_tri_ix;
            r_s_kind <= e_kind;
            r_s_a    <= e_a;
            r_s_b    <= e_b;
            r_s_c    <= e_c;
            r_s_wp   <= e_wp;
            r_s_vt   <= e_vt;
        end else if (i_cmd.emit) begin
            r_k  <= r_k + 6'd1;
            r_vk <= r_vk + 16'd1;
            r_wp <= r_wp + 16'd3;
        end
    end

    assign o_sts.has_result = (e_count != 6'd0);
    assign o_sts.last       = (r_k == (r_count - 6'd1));

    // build the next word from the emit step
    always_comb begin
        w_kind = KIND_TRIANGLE;
        w_a    = r_s_a;
        w_b    = r_s_b;
        w_c    = r_s_c;
        w_wp   = r_wp;
        w_vt   = '0;
        case (r_op)
            OP_FAN: begin
                w_a = r_v;
                w_b = r_vk + 16'd1;
                w_c = r_vk + 16'd2;
            end
            OP_STRIP: begin
                if (r_k[0]) begin
                    w_a = r_vk + 16'd2;
                    w_b = r_vk + 16'd1;
                    w_c = r_vk;
                end else begin
                    w_a = r_vk;
                    w_b = r_vk + 16'd1;
                    w_c = r_vk + 16'd2;
                end
            end
            OP_GRID: begin
                w_a = r_v + 16'(grid_idx(r_k[2:0], 2'd0));
                w_b = r_v + 16'(grid_idx(r_k[2:0], 2'd1));
                w_c = r_v + 16'(grid_idx(r_k[2:0], 2'd2));
            end
            default: begin
                w_kind = r_s_kind;
                w_wp   = r_s_wp;
                w_vt   = r_s_vt;
            end
        endcase
    end

    // result word register, one word per emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_last   <= o_sts.last;
            r_kind   <= w_kind;
            r_a      <= w_a;
            r_b      <= w_b;
            r_c      <= w_c;
            r_out_wp <= w_wp;
            r_out_vt <= w_vt;
        end
    end

    assign o_kind           = r_kind;
    assign o_index_a        = r_a;
    assign o_index_b        = r_b;
    assign o_index_c        = r_c;
    assign o_write_position = r_out_wp;
    assign o_vertex_total   = r_out_vt;
    assign o_last           = r_last;

`ifndef SYNTHESIS
    // an evaluation never asks for more words than a polygon can give
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> (e_count <= 6'd62))
        else $error("result count out of range");

    // the step counter never runs past the result count
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_k < r_count))
        else $error("emit past last result");

    // an error word leaves the batch counters untouched
    a_error_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && e_op == OP_SINGLE && e_kind == KIND_ERROR && e_count != 6'd0)
        |=> ($stable(r_tri_v) && $stable(r_tri_ix) && $stable(r_line_v)
             && $stable(r_line_ix)))
        else $error("counters changed on capacity error");
`endif

endmodule

`default_nettype wire

### src/primitive_index_generator.sv
// Primitive index generator top level: turns fan, strip, line, grid, indexed fan and
// flush commands into triangle-list and line-list index words and report/error words.
// Channels: i_item (sink) takes one command word per valid/ready handshake; o_res
// (source) gives result words, each with last set on the final word of a command.
// Sequence: a command is taken, evaluated in the next cycle, and its result words
// then leave at one word per cycle while the receiver does not stall; no new command
// is taken until the last word of the current one is emitted, or until evaluation
// ends for a command with no result. The first word is written into the output
// register in the emit state, once the output slot is free.
// Ready on i_item is high while the controller is idle, also while the last word of
// the previous command still waits in the output register.
// When the receiver stalls, the word holds in the output register and the emit
// sequence pauses; nothing is dropped.
// Reset (synchronous, active low) clears all batch counts, the indexed fan state and
// the output valid flag; no clearing pass is needed.
// depends on pig_pkg, pig_in_if, pig_out_if, pig_ctrl and pig_dpath
`default_nettype none

module primitive_index_generator import pig_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pig_in_if.sink    i_item,
    pig_out_if.source o_res
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    // sequencing
    pig_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // counters, checks and result word
    pig_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (i_item.mode),
        .i_vertex_count   (i_item.vertex_count),
        .i_index_offset   (i_item.index_offset),
        .i_local_index    (i_item.local_index),
        .i_first_of_list  (i_item.first_of_list),
        .o_kind           (o_res.kind),
        .o_index_a        (o_res.index_a),
        .o_index_b        (o_res.index_b),
        .o_index_c        (o_res.index_c),
        .o_write_position (o_res.write_position),
        .o_vertex_total   (o_res.vertex_total),
        .o_last           (o_res.last)
    );

    assign i_item.ready = in_ready;
    assign o_res.valid  = out_valid;

endmodule

`default_nettype wire
